/* src/wsad_pkg.sv */
// Package with shared types and constants of the sigma anomaly detector.
`timescale 1ns / 1ps
package wsad_pkg;
	localparam int STREAMS = 64;
	localparam int IDX_W = 6;
	localparam int SAMPLE_W = 32;
	localparam logic [15:0] SIGMA_RESET = 16'd768;
	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_DIV,
		ST_MEAN,
		ST_MUL,
		ST_M2,
		ST_CMP,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		MOP_INC,
		MOP_DEVSQ,
		MOP_LHS,
		MOP_KK,
		MOP_RHS
	} mop_t;
endpackage

/* src/welford_sigma_anomaly_detector.sv */
// Top level of the per-stream Welford k-sigma anomaly detector.
//
// channel | signals                            | direction
// s_axis  | s_axis_tvalid/tready/tdata         | in : sample per stream
// m_axis  | m_axis_tvalid/tready/tdata/tuser   | out: flags and running mean
// cfg     | cfg_we, cfg_wdata                  | in : sigma multiplier k
//
// A first sample skips the divider and multiplier and goes straight to its result.
// A later sample passes through the 33-step radix-2 divider and the 32x32 multiplier,
// which builds each wide product from four partial products, one per cycle; when M2
// stays zero, the comparison multiplies are skipped and the sample is not flagged.
// Reset clears all counts at once through per-stream valid flags.
// The input is not ready from acceptance until the result has been taken.
`timescale 1ns / 1ps
module welford_sigma_anomaly_detector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: stream_index [5:0], sample_value [37:6], zeros [39:38]
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: stream_index_out [5:0], running_mean [37:6], zeros [39:38]
	output logic [39:0] m_axis_tdata,
	// tuser: outlier [0], first_sample [1]
	output logic [1:0]  m_axis_tuser
);
	import wsad_pkg::*;

	logic [31:0] count_mem [STREAMS];
	logic [31:0] mean_mem  [STREAMS];
	logic [63:0] m2_mem    [STREAMS];
	logic [STREAMS-1:0] valid_q;

	state_t state_q, state_d;
	logic [15:0] sigma_q;
	logic [IDX_W-1:0] idx_q;
	logic signed [32:0] x_q;
	logic [31:0] cnt_rd_q, mean_rd_q, n_q;
	logic [63:0] m2_rd_q;
	logic signed [32:0] d1_q, d2_q;
	logic [32:0] num_q, quo_q, rem_q;
	logic [5:0] step_q;
	logic neg_q;
	logic [63:0] ma_q, mb_q;
	logic [127:0] acc_q;
	logic pa_q, pb_q;
	mop_t mop_q;
	logic [127:0] lhs_q;
	logic [63:0] m2_new_q;
	logic first_q, anom_q;
	logic [31:0] mean_out_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] pprod;
	logic [127:0] acc_nx;
	logic [33:0] rem_sh;
	logic [32:0] mag_d1, mag_d2;
	logic signed [32:0] mean_ext, d1_nx;
	logic [64:0] m2_sum;
	logic mul_last;

	always_comb begin
		mul_a = pa_q ? ma_q[63:32] : ma_q[31:0];
		mul_b = pb_q ? mb_q[63:32] : mb_q[31:0];
		pprod = mul_a * mul_b;
		acc_nx = acc_q + (128'(pprod) << (7'(pa_q) * 7'd32 + 7'(pb_q) * 7'd32));
		mul_last = pa_q && pb_q;
		rem_sh = {rem_q, num_q[32]};
		mean_ext = $signed({mean_rd_q[31], mean_rd_q});
		d1_nx = x_q - mean_ext;
		mag_d1 = d1_q[32] ? 33'(-d1_q) : 33'(d1_q);
		mag_d2 = d2_q[32] ? 33'(-d2_q) : 33'(d2_q);
		m2_sum = {1'b0, m2_rd_q} + {1'b0, acc_q[63:0]};
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_axis_tvalid) state_d = ST_READ;
			ST_READ: state_d = ST_LOAD;
			ST_LOAD: state_d = (cnt_rd_q == 32'd0) ? ST_OUT : ST_DIV;
			ST_DIV:  if (step_q == 6'd32) state_d = ST_MEAN;
			ST_MEAN: state_d = ST_MUL;
			ST_MUL:  if (mul_last) begin
				unique case (mop_q)
					MOP_INC: state_d = ST_M2;
					MOP_RHS: state_d = ST_CMP;
					default: state_d = ST_MUL;
				endcase
			end
			ST_M2:   state_d = (m2_sum[64] || m2_sum[63:0] != 64'd0) ? ST_MUL : ST_OUT;
			ST_CMP:  state_d = ST_OUT;
			ST_OUT:  if (m_axis_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		m_axis_tvalid = (state_q == ST_OUT);
		m_axis_tdata = {2'b00, mean_out_q, idx_q};
		m_axis_tuser = {first_q, anom_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sigma_q <= SIGMA_RESET;
			valid_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) sigma_q <= cfg_wdata;
			if (state_q == ST_LOAD) valid_q[idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				idx_q <= s_axis_tdata[5:0];
				x_q <= {s_axis_tdata[37], s_axis_tdata[37:6]};
			end
			ST_READ: begin
				cnt_rd_q <= valid_q[idx_q] ? count_mem[idx_q] : 32'd0;
				mean_rd_q <= mean_mem[idx_q];
				m2_rd_q <= m2_mem[idx_q];
			end
			ST_LOAD: begin
				anom_q <= 1'b0;
				if (cnt_rd_q == 32'd0) begin
					first_q <= 1'b1;
					mean_out_q <= x_q[31:0];
					count_mem[idx_q] <= 32'd1;
					mean_mem[idx_q] <= x_q[31:0];
					m2_mem[idx_q] <= 64'd0;
				end else begin
					first_q <= 1'b0;
					n_q <= (cnt_rd_q == COUNT_MAX) ? cnt_rd_q : cnt_rd_q + 32'd1;
					count_mem[idx_q] <= (cnt_rd_q == COUNT_MAX) ? cnt_rd_q : cnt_rd_q + 32'd1;
					d1_q <= d1_nx;
					neg_q <= d1_nx[32];
					num_q <= d1_nx[32] ? 33'(-d1_nx) : 33'(d1_nx);
					rem_q <= '0;
					quo_q <= '0;
					step_q <= '0;
				end
			end
			ST_DIV: begin
				num_q <= {num_q[31:0], 1'b0};
				if (rem_sh >= {2'b00, n_q}) begin
					rem_q <= 33'(rem_sh - {2'b00, n_q});
					quo_q <= {quo_q[31:0], 1'b1};
				end else begin
					rem_q <= rem_sh[32:0];
					quo_q <= {quo_q[31:0], 1'b0};
				end
				step_q <= step_q + 6'd1;
			end
			ST_MEAN: begin
				d2_q <= neg_q ? 33'(x_q - ({mean_rd_q[31], mean_rd_q} - quo_q))
					: 33'(x_q - ({mean_rd_q[31], mean_rd_q} + quo_q));
				mean_out_q <= neg_q ? 32'(mean_rd_q - quo_q[31:0])
					: 32'(mean_rd_q + quo_q[31:0]);
				mean_mem[idx_q] <= neg_q ? 32'(mean_rd_q - quo_q[31:0])
					: 32'(mean_rd_q + quo_q[31:0]);
				ma_q <= {31'd0, mag_d1};
				mb_q <= {31'd0, 33'(mag_d1 - quo_q)};
				mop_q <= MOP_INC;
				pa_q <= '0;
				pb_q <= '0;
				acc_q <= '0;
			end
			ST_MUL: begin
				acc_q <= (mul_last && mop_q != MOP_INC && mop_q != MOP_RHS) ? '0 : acc_nx;
				if (!pb_q) pb_q <= 1'b1;
				else begin
					pb_q <= 1'b0;
					pa_q <= !pa_q;
				end
				if (mul_last) begin
					unique case (mop_q)
						MOP_INC: ;
						MOP_DEVSQ: begin
							mop_q <= MOP_LHS;
							ma_q <= acc_nx[63:0];
							mb_q <= {32'd0, n_q - 32'd1};
						end
						MOP_LHS: begin
							mop_q <= MOP_KK;
							lhs_q <= acc_nx << 16;
							ma_q <= {48'd0, sigma_q};
							mb_q <= {48'd0, sigma_q};
						end
						MOP_KK: begin
							mop_q <= MOP_RHS;
							ma_q <= m2_new_q;
							mb_q <= acc_nx[63:0];
						end
						MOP_RHS: ;
						default: ;
					endcase
				end
			end
			ST_M2: begin
				m2_new_q <= m2_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : m2_sum[63:0];
				m2_mem[idx_q] <= m2_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : m2_sum[63:0];
				ma_q <= {31'd0, mag_d2};
				mb_q <= {31'd0, mag_d2};
				mop_q <= MOP_DEVSQ;
				pa_q <= '0;
				pb_q <= '0;
				acc_q <= '0;
			end
			ST_CMP: anom_q <= lhs_q > acc_q;
			ST_OUT: ;
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && m_axis_tuser[1]) |-> !m_axis_tuser[0])
		else $error("first sample flagged");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> step_q <= 6'd32)
		else $error("divider overran");
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid)
		else $error("input ready while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |=> valid_q[$past(idx_q)])
		else $error("stream not marked valid");
endmodule
